/* rtl/irf_pkg.sv */
package irf_pkg;

	parameter int WORD_BITS_DEF = 32;

	typedef enum logic [1:0] {
		CMD_UDEC = 2'd0,
		CMD_SDEC = 2'd1,
		CMD_OCT  = 2'd2,
		CMD_HEX  = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e cmd;
		logic neg;
	} hdr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE0,
		ST_PRE1,
		ST_DIGIT,
		ST_SUFFIX
	} state_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

/* rtl/irf_serializer.sv */
module irf_serializer #(
	parameter int NDIG = 11
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       ld_valid,
	output logic                       ld_ready,
	input  irf_pkg::hdr_t              hdr,
	input  logic [$clog2(NDIG)-1:0]    top_idx,
	input  logic [3:0]                 digits [NDIG],
	output logic [7:0]                 character,
	output logic                       last,
	output logic                       strobe
);

	localparam int IDXW = $clog2(NDIG);

	irf_pkg::state_t state_q, state_nx, start_st;
	irf_pkg::hdr_t   hdr_q;
	logic [IDXW-1:0] didx_q;
	logic [3:0]      dig_q [NDIG];
	logic            free;
	logic            load;

	assign free     = (state_q == irf_pkg::ST_IDLE) || last;
	assign ld_ready = free;
	assign load     = ld_valid && free;

	always_comb begin
		unique case (hdr.cmd) inside
			irf_pkg::CMD_UDEC: start_st = irf_pkg::ST_DIGIT;
			irf_pkg::CMD_SDEC: start_st = hdr.neg ? irf_pkg::ST_PRE0 : irf_pkg::ST_DIGIT;
			irf_pkg::CMD_OCT, irf_pkg::CMD_HEX: start_st = irf_pkg::ST_PRE0;
			default: start_st = irf_pkg::ST_DIGIT;
		endcase
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		if (free) begin
			state_nx = ld_valid ? start_st : irf_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				irf_pkg::ST_PRE0: state_nx = (hdr_q.cmd == irf_pkg::CMD_HEX) ?
					irf_pkg::ST_PRE1 : irf_pkg::ST_DIGIT;
				irf_pkg::ST_PRE1: state_nx = irf_pkg::ST_DIGIT;
				// Only unsigned decimal gets here with the index at zero.
				irf_pkg::ST_DIGIT: state_nx = (didx_q == '0) ?
					irf_pkg::ST_SUFFIX : irf_pkg::ST_DIGIT;
				default: state_nx = irf_pkg::ST_IDLE;
			endcase
		end
	end

	// Outputs.
	always_comb begin
		strobe    = 1'b1;
		character = '0;
		last      = 1'b0;
		unique case (state_q)
			irf_pkg::ST_IDLE: strobe = 1'b0;
			irf_pkg::ST_PRE0: character = hdr_q.neg ? irf_pkg::CH_MINUS : irf_pkg::CH_ZERO;
			irf_pkg::ST_PRE1: character = irf_pkg::CH_X;
			irf_pkg::ST_DIGIT: begin
				character = irf_pkg::digit_char(dig_q[didx_q]);
				last      = (didx_q == '0) && (hdr_q.cmd != irf_pkg::CMD_UDEC);
			end
			irf_pkg::ST_SUFFIX: begin
				character = irf_pkg::CH_SPACE;
				last      = 1'b1;
			end
			default: strobe = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hdr_q  <= hdr;
			didx_q <= top_idx;
			dig_q  <= digits;
		end else if (state_q == irf_pkg::ST_DIGIT && didx_q != '0) begin
			didx_q <= didx_q - 1'b1;
		end
	end

endmodule

/* rtl/integer_radix_formatter.sv */
// After start is taken, the value passes the entry stage, the double-dabble stages, the
// selection register and the serializer state before the first character is on the ports;
// the rest follow one per cycle with no gaps. Throughput: one value per text, 1 to 12
// characters at 32 bits, set by the one-character-per-cycle output; the conversion pipeline
// is four bits per stage. Reset clears all valid bits and the output state; busy is high
// while all stages are full and the serializer is busy. Results cannot be held off by the receiver.
module integer_radix_formatter #(
	parameter int WORD_BITS = irf_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           command,
	input  logic [WORD_BITS-1:0] value,
	output logic [7:0]           character,
	output logic                 last,
	output logic                 strobe
);

	localparam int NDIG = (WORD_BITS + 2) / 3;
	localparam int IDXW = $clog2(NDIG);
	localparam int NST  = (WORD_BITS + 3) / 4;
	localparam int PADW = 4 * NST;
	localparam int DIGW = 4 * NDIG;

	// Index 0 is the entry stage; index j holds the BCD after 4*j bits.
	logic                 vld_s [NST+1];
	irf_pkg::hdr_t        hdr_s [NST+1];
	logic [WORD_BITS-1:0] mag_s [NST+1];
	logic [PADW-1:0]      bin_s [NST+1];
	logic [DIGW-1:0]      bcd_s [NST+1];
	logic [PADW-1:0]      bin_nx [NST];
	logic [DIGW-1:0]      bcd_nx [NST];
	logic                 rdy [NST+2];

	logic                 fvld_s;
	irf_pkg::hdr_t        fhdr_s;
	logic [IDXW-1:0]      fidx_s;
	logic [3:0]           fdig_s [NDIG];

	logic [3:0]           sel_dig [NDIG];
	logic [IDXW-1:0]      sel_idx;
	logic                 ser_ready;
	logic                 accept;
	logic                 neg_in;

	assign busy   = !rdy[0];
	assign accept = start && rdy[0];
	assign neg_in = (irf_pkg::cmd_e'(command) == irf_pkg::CMD_SDEC) && value[WORD_BITS-1];

	assign rdy[NST+1] = !fvld_s || ser_ready;

	genvar j;
	generate
		for (j = 0; j <= NST; j++) begin : g_rdy
			assign rdy[j] = !vld_s[j] || rdy[j+1];
		end
	endgenerate

	// Entry stage: take the magnitude of a negative signed value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (rdy[0]) begin
			vld_s[0] <= start;
		end
	end

	// The padding bits sit above the word so that they shift in first as zeros.
	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s[0].cmd <= irf_pkg::cmd_e'(command);
			hdr_s[0].neg <= neg_in;
			mag_s[0]     <= neg_in ? -value : value;
			bin_s[0]     <= PADW'(neg_in ? -value : value);
			bcd_s[0]     <= '0;
		end
	end

	// Double-dabble stages, four bits each.
	generate
		for (j = 0; j < NST; j++) begin : g_dab
			always_comb begin : dab
				logic [DIGW-1:0] b;
				logic [PADW-1:0] r;
				b = bcd_s[j];
				r = bin_s[j];
				for (int t = 0; t < 4; t++) begin
					for (int d = 0; d < NDIG; d++) begin
						if (b[4*d +: 4] >= 4'd5) begin
							b[4*d +: 4] = b[4*d +: 4] + 4'd3;
						end
					end
					b = {b[DIGW-2:0], r[PADW-1]};
					r = {r[PADW-2:0], 1'b0};
				end
				bcd_nx[j] = b;
				bin_nx[j] = r;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[j+1] <= 1'b0;
				end else if (rdy[j+1]) begin
					vld_s[j+1] <= vld_s[j];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[j+1] && vld_s[j]) begin
					hdr_s[j+1] <= hdr_s[j];
					mag_s[j+1] <= mag_s[j];
					bin_s[j+1] <= bin_nx[j];
					bcd_s[j+1] <= bcd_nx[j];
				end
			end
		end
	endgenerate

	// Digit selection for the chosen radix and the index of the leading digit.
	always_comb begin : sel
		logic [DIGW-1:0] mpad;
		mpad    = DIGW'(mag_s[NST]);
		sel_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			case (hdr_s[NST].cmd)
				irf_pkg::CMD_OCT: sel_dig[i] = {1'b0, mpad[3*i +: 3]};
				irf_pkg::CMD_HEX: sel_dig[i] = mpad[4*i +: 4];
				default:          sel_dig[i] = bcd_s[NST][4*i +: 4];
			endcase
			if (sel_dig[i] != 4'd0) begin
				sel_idx = IDXW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvld_s <= 1'b0;
		end else if (rdy[NST+1]) begin
			fvld_s <= vld_s[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NST+1] && vld_s[NST]) begin
			fhdr_s <= hdr_s[NST];
			fidx_s <= sel_idx;
			fdig_s <= sel_dig;
		end
	end

	irf_serializer #(
		.NDIG(NDIG)
	) u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (fvld_s),
		.ld_ready (ser_ready),
		.hdr      (fhdr_s),
		.top_idx  (fidx_s),
		.digits   (fdig_s),
		.character(character),
		.last     (last),
		.strobe   (strobe)
	);

	// The pipeline can only back up behind a text that is being sent.
	a_busy_sending: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe)
		else $error("busy without an active text");

	// A text never ends on its prefix.
	a_last_not_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> (character != irf_pkg::CH_MINUS && character != irf_pkg::CH_X))
		else $error("text ended on a prefix character");

	// Characters of one text come in consecutive cycles.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !last) |=> strobe)
		else $error("gap inside a text");

endmodule

/* dv/tb_integer_radix_formatter.sv */
module tb_integer_radix_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_W      = 32;
	localparam int ITEM_COUNT  = 330;
	localparam int QUIET_TAIL  = 60;
	localparam int DRAIN_WAIT  = 24;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [7:0] character;
		logic       last;
	} text_char_t;

	class char_scoreboard;
		text_char_t pending_chars[$];
		int         words_seen;
		int         words_per_cmd[4];
		int         chars_checked;
		int         mismatches;

		function automatic logic [7:0] digit_code(input int unsigned d);
			return (d < 10) ? irf_pkg::CH_ZERO + 8'(d) : 8'h41 + 8'(d - 10);
		endfunction

		// Builds the expected text of one word and queues it character by character.
		function void note_word(input irf_pkg::cmd_e cmd, input logic [WORD_W-1:0] word);
			logic [7:0]        text[$];
			logic [7:0]        digits[$];
			logic [WORD_W-1:0] mag;
			int unsigned       base;
			text_char_t        ch;
			mag = word;
			base = 10;
			case (cmd)
				irf_pkg::CMD_SDEC: begin
					if (word[WORD_W-1]) begin
						text.push_back(irf_pkg::CH_MINUS);
						mag = -word;
					end
				end
				irf_pkg::CMD_OCT: begin
					text.push_back(irf_pkg::CH_ZERO);
					base = 8;
				end
				irf_pkg::CMD_HEX: begin
					text.push_back(irf_pkg::CH_ZERO);
					text.push_back(irf_pkg::CH_X);
					base = 16;
				end
				default: ;
			endcase
			if (mag == '0) begin
				digits.push_back(irf_pkg::CH_ZERO);
			end
			while (mag != '0) begin
				digits.push_front(digit_code(mag % base));
				mag = mag / base;
			end
			foreach (digits[i]) text.push_back(digits[i]);
			if (cmd == irf_pkg::CMD_UDEC) begin
				text.push_back(irf_pkg::CH_SPACE);
			end
			foreach (text[i]) begin
				ch.character = text[i];
				ch.last = (i == text.size() - 1);
				pending_chars.push_back(ch);
			end
			words_seen++;
			words_per_cmd[int'(cmd)]++;
		endfunction

		function void check_char(input logic [7:0] character, input logic last);
			text_char_t want;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] unexpected character 0x%02h last=%0b with nothing pending",
						$realtime, character, last);
				end
				return;
			end
			want = pending_chars.pop_front();
			chars_checked++;
			if (character !== want.character || last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display({"[%0t] character: expected 0x%02h got 0x%02h, ",
						"last: expected %0b got %0b"},
						$realtime, want.character, character, want.last, last);
				end
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	irf_pkg::cmd_e     command;
	logic [WORD_W-1:0] value;
	logic [7:0]        character;
	logic              last;
	logic              strobe;

	char_scoreboard sb;
	int unsigned    cycle_count;

	integer_radix_formatter #(
		.WORD_BITS(WORD_W)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.value    (value),
		.character(character),
		.last     (last),
		.strobe   (strobe)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_word(command, value);
			end
			if (strobe) begin
				sb.check_char(character, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d characters pending",
				cycle_count, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_word(input irf_pkg::cmd_e cmd, input logic [WORD_W-1:0] word);
		start <= 1'b1;
		command <= cmd;
		value <= word;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		start <= 1'b0;
		repeat ($urandom_range(1, 7)) @(negedge clk);
	endtask

	function automatic logic [WORD_W-1:0] random_word(input irf_pkg::cmd_e cmd);
		logic [WORD_W-1:0] word;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: word = '0;
					1: word = '1;
					2: word = {1'b1, {(WORD_W-1){1'b0}}};
					default: word = {1'b0, {(WORD_W-1){1'b1}}};
				endcase
			end
			1, 2: word = -($urandom >> $urandom_range(0, 31));
			default: word = $urandom >> $urandom_range(0, 31);
		endcase
		return word;
	endfunction

	initial begin
		logic [WORD_W-1:0] edge_words[5];
		logic [WORD_W-1:0] step_words[4];
		irf_pkg::cmd_e     cmd;
		bit                idling;
		sb = new();
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		command = irf_pkg::CMD_UDEC;
		value = '0;
		edge_words = '{'0, 1, '1, 32'h8000_0000, 32'h7FFF_FFFF};
		// Words that add a digit in each format.
		step_words = '{32'd10, 32'hFFFF_FFF6, 32'd8, 32'd16};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int c = 0; c < 4; c++) begin
			foreach (edge_words[i]) send_word(irf_pkg::cmd_e'(c), edge_words[i]);
		end
		for (int c = 0; c < 4; c++) send_word(irf_pkg::cmd_e'(c), step_words[c]);

		for (int n = 0; n < ITEM_COUNT - 24; n++) begin
			// Some stretches run back to back, and the tail has no gaps at all.
			idling = (n < ITEM_COUNT - 24 - QUIET_TAIL) && !(n >= 100 && n < 140);
			if (n == 150) begin
				start <= 1'b0;
				while (sb.pending() != 0) @(negedge clk);
			end else if (idling && $urandom_range(0, 3) == 0) begin
				sender_gap();
			end
			cmd = irf_pkg::cmd_e'($urandom_range(0, 3));
			send_word(cmd, random_word(cmd));
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Formatted %0d words: %0d unsigned, %0d signed, %0d octal, %0d hex.",
			sb.words_seen, sb.words_per_cmd[0], sb.words_per_cmd[1],
			sb.words_per_cmd[2], sb.words_per_cmd[3]);
		$display("Checked %0d characters with %0d mismatches and %0d left pending.",
			sb.chars_checked, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
